[design/button_press_hold_debouncer_defines.svh]
`ifndef BUTTON_PRESS_HOLD_DEBOUNCER_DEFINES_SVH
`define BUTTON_PRESS_HOLD_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, sampled on the block clock and disabled in reset.
`define BPHD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, sampled on the block clock and disabled in reset.
`define BPHD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[design/bphd_pkg.sv]
`timescale 1ns / 1ps

package bphd_pkg;

   // Default width of the internal time arithmetic.
   localparam int TIME_WIDTH_DEF = 32;

   // Configuration port geometry: two 16-bit registers at byte addresses 0 and 4.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CFG_WIDTH      = 16;

   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_HOLD     = 1'b1;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd1000;

   // Button state codes.
   localparam logic [1:0] ST_IDLE       = 2'd0;
   localparam logic [1:0] ST_PRESS_PEND = 2'd1;
   localparam logic [1:0] ST_HELD       = 2'd2;
   localparam logic [1:0] ST_REL_PEND   = 2'd3;

   // Event codes.
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_HOLD    = 2'd2;
   localparam logic [1:0] EV_RELEASE = 2'd3;

   typedef struct packed {
      logic        raw_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [1:0] button_state;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_window_ms;
      logic [CFG_WIDTH-1:0] hold_time_ms;
   } cfg_type;

endpackage

[design/bphd_csr.sv]
`timescale 1ns / 1ps

module bphd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bphd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bphd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bphd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output bphd_pkg::cfg_type                   cfg
);
   import bphd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[CSR_ADDR_WIDTH-1];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DEBOUNCE: cfg_in.debounce_window_ms = csr_pwdata[CFG_WIDTH-1:0];
            REG_HOLD:     cfg_in.hold_time_ms       = csr_pwdata[CFG_WIDTH-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEBOUNCE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_window_ms);
         REG_HOLD:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.hold_time_ms);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_window_ms <= DEBOUNCE_RESET;
         cfg_ff.hold_time_ms       <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/bphd_core.sv]
`timescale 1ns / 1ps
`include "button_press_hold_debouncer_defines.svh"

module bphd_core #(
   parameter int TIME_WIDTH = bphd_pkg::TIME_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bphd_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  bphd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bphd_pkg::rsp_type rsp_data
);
   import bphd_pkg::*;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_type               s1_data_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_type               out_data_ff;
   rsp_type               out_data_in;
   logic [1:0]            mode_ff;
   logic [1:0]            mode_in;
   logic [TIME_WIDTH-1:0] window_start_ff;
   logic [TIME_WIDTH-1:0] window_start_in;
   logic [TIME_WIDTH-1:0] press_start_ff;
   logic [TIME_WIDTH-1:0] press_start_in;
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] win_elapsed;
   logic [TIME_WIDTH-1:0] hold_elapsed;
   logic                  win_done;
   logic                  hold_done;
   logic                  level_high;
   logic [1:0]            event_in;
   logic                  advance;
   logic                  fire;

   // The output register can take a new result when it is empty or being drained.
   assign advance     = !out_valid_ff || !rsp_stall;
   assign fire        = s1_valid_ff && advance;
   assign req_stall   = s1_valid_ff && !advance;
   assign s1_valid_in = req_stall || req_valid;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   // Time is carried at TIME_WIDTH bits; elapsed values wrap modulo that width.
   assign now_t        = TIME_WIDTH'(s1_data_ff.now_ms);
   assign level_high   = s1_data_ff.raw_level;
   assign win_elapsed  = now_t - window_start_ff;
   assign hold_elapsed = now_t - press_start_ff;
   assign win_done     = win_elapsed >= TIME_WIDTH'(cfg.debounce_window_ms);
   assign hold_done    = hold_elapsed >= TIME_WIDTH'(cfg.hold_time_ms);

   always_comb begin
      mode_in         = mode_ff;
      window_start_in = window_start_ff;
      press_start_in  = press_start_ff;
      event_in        = EV_NONE;
      case (mode_ff)
         ST_IDLE: begin
            if (!level_high) begin
               window_start_in = now_t;
               mode_in         = ST_PRESS_PEND;
            end
         end
         ST_PRESS_PEND: begin
            if (level_high) begin
               mode_in = ST_IDLE;
            end else if (win_done) begin
               press_start_in = now_t;
               event_in       = EV_PRESS;
               mode_in        = ST_HELD;
            end
         end
         ST_HELD: begin
            if (level_high) begin
               window_start_in = now_t;
               mode_in         = ST_REL_PEND;
            end else if (hold_done) begin
               // Re-arm so that hold events repeat every hold period.
               press_start_in = now_t;
               event_in       = EV_HOLD;
            end
         end
         default: begin
            // Release pending: a low pin is a bounce and restarts a press window.
            if (!level_high) begin
               window_start_in = now_t;
               mode_in         = ST_PRESS_PEND;
            end else if (win_done) begin
               event_in = EV_RELEASE;
               mode_in  = ST_IDLE;
            end
         end
      endcase
   end

   assign out_data_in.event_res    = event_in;
   assign out_data_in.button_state = mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         mode_ff         <= ST_IDLE;
         window_start_ff <= '0;
         press_start_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            mode_ff         <= mode_in;
            window_start_ff <= window_start_in;
            press_start_ff  <= press_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `BPHD_ASSERT_SAME(a_press_to_held, out_valid_ff && out_data_ff.event_res == EV_PRESS,
                     out_data_ff.button_state == ST_HELD)
   `BPHD_ASSERT_SAME(a_hold_in_held, out_valid_ff && out_data_ff.event_res == EV_HOLD,
                     out_data_ff.button_state == ST_HELD)
   `BPHD_ASSERT_SAME(a_release_to_idle, out_valid_ff && out_data_ff.event_res == EV_RELEASE,
                     out_data_ff.button_state == ST_IDLE)
   `BPHD_ASSERT_NEXT(a_state_only_on_fire, !fire, $stable(mode_ff))

endmodule

[design/button_press_hold_debouncer.sv]
`timescale 1ns / 1ps
// Press/hold button debouncer.
// The request channel (req_valid, req_stall, req_data) takes one transaction per
// sample: the raw active-low pin level and a wrapping millisecond timestamp.
// The response channel (rsp_valid, rsp_stall, rsp_data) returns exactly one
// transaction per request, carrying the event (none, press, hold, release) and
// the button state after that sample.
// A request is taken into the input register, and its response is then written
// into the output register once that register is empty or being drained.
// Throughput is one transaction per cycle unless the receiver stalls; the
// state update is a single pass of two wrapping subtract-and-compare paths
// between those two registers. When the receiver stalls, the pending response
// holds, and req_stall rises as soon as the input register holds a request.
// Synchronous reset empties both registers, returns the machine to idle with
// zero window and press times, and loads a 20 ms debounce window and a
// 1000 ms hold period. The APB-style csr_ port writes the debounce window at
// byte address 0 and the hold period at address 4; write it only while idle.
module button_press_hold_debouncer #(
   parameter int TIME_WIDTH = bphd_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bphd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bphd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bphd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bphd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bphd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import bphd_pkg::*;

   // Current configuration, shared by the whole state machine.
   cfg_type cfg;

   bphd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Input register, state machine and output register.
   bphd_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/bphd_event_checker.sv]
`timescale 1ns / 1ps

// Passive checker for the press/hold debouncer. It follows the configuration
// port and the request channel, predicts one response per accepted request
// and compares each accepted response with the oldest prediction.
module bphd_event_checker
   import bphd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic                      csr_pready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output int                        error_count,
   output int                        pending_count
);

   logic [CFG_WIDTH-1:0] window_cfg;
   logic [CFG_WIDTH-1:0] hold_cfg;
   logic [1:0]           btn_mode;
   logic [31:0]          window_t0;
   logic [31:0]          press_t0;
   rsp_type              expected_events[$];
   int                   mismatches = 0;

   // Advances the button machine by one sample and returns the response it owes.
   function automatic rsp_type debounce_step(input req_type sample);
      rsp_type     outcome;
      logic [31:0] since_window;
      logic [31:0] since_press;
      since_window = sample.now_ms - window_t0;
      since_press = sample.now_ms - press_t0;
      outcome.event_res = EV_NONE;
      case (btn_mode)
         ST_IDLE: begin
            if (!sample.raw_level) begin
               window_t0 = sample.now_ms;
               btn_mode = ST_PRESS_PEND;
            end
         end
         ST_PRESS_PEND: begin
            if (sample.raw_level) begin
               btn_mode = ST_IDLE;
            end else if (since_window >= {16'd0, window_cfg}) begin
               press_t0 = sample.now_ms;
               outcome.event_res = EV_PRESS;
               btn_mode = ST_HELD;
            end
         end
         ST_HELD: begin
            if (sample.raw_level) begin
               window_t0 = sample.now_ms;
               btn_mode = ST_REL_PEND;
            end else if (since_press >= {16'd0, hold_cfg}) begin
               outcome.event_res = EV_HOLD;
               press_t0 = sample.now_ms;
            end
         end
         default: begin
            if (!sample.raw_level) begin
               window_t0 = sample.now_ms;
               btn_mode = ST_PRESS_PEND;
            end else if (since_window >= {16'd0, window_cfg}) begin
               outcome.event_res = EV_RELEASE;
               btn_mode = ST_IDLE;
            end
         end
      endcase
      outcome.button_state = btn_mode;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type                   want;
      logic [CSR_DATA_WIDTH-1:0] read_want;
      if (reset) begin
         window_cfg = DEBOUNCE_RESET;
         hold_cfg = HOLD_RESET;
         btn_mode = ST_IDLE;
         window_t0 = '0;
         press_t0 = '0;
         expected_events.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_DEBOUNCE) begin
                  window_cfg = csr_pwdata[CFG_WIDTH-1:0];
               end else if (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_HOLD) begin
                  hold_cfg = csr_pwdata[CFG_WIDTH-1:0];
               end
            end else begin
               read_want = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_DEBOUNCE) ?
                           CSR_DATA_WIDTH'(window_cfg) : CSR_DATA_WIDTH'(hold_cfg);
               if (csr_prdata !== read_want) begin
                  $error("csr_prdata mismatch at address %0d: expected %0d, actual %0d",
                         csr_paddr, read_want, csr_prdata);
                  mismatches++;
               end
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected response: event_res %0d, button_state %0d",
                      rsp_data.event_res, rsp_data.button_state);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_data.event_res !== want.event_res) begin
                  $error("event_res mismatch: expected %0d, actual %0d",
                         want.event_res, rsp_data.event_res);
                  mismatches++;
               end
               if (rsp_data.button_state !== want.button_state) begin
                  $error("button_state mismatch: expected %0d, actual %0d",
                         want.button_state, rsp_data.button_state);
                  mismatches++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            expected_events.push_back(debounce_step(req_data));
         end
      end
      error_count <= mismatches;
      pending_count <= expected_events.size();
   end

endmodule

[sim/button_press_hold_debouncer_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the press/hold debouncer. The checker instance
// beside the block does all prediction and comparison; this module only
// produces sample transactions, configuration writes and reads, and
// response back-pressure, then reports the outcome.
module button_press_hold_debouncer_tb;
   import bphd_pkg::*;

   // Pin levels: the button is active low.
   localparam logic PIN_LOW  = 1'b0;
   localparam logic PIN_HIGH = 1'b1;

   // Hard ceiling on the run length in clock cycles.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Cycles of quiet after the last response, so the block is truly idle.
   localparam int DRAIN_CYCLES = 8;
   // Length of a deliberate receiver hold-off, long enough to back up the input.
   localparam int HOLD_OFF_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int                        error_count;
   int                        pending_count;
   int                        cycle_count = 0;

   // Stimulus-side view of time and configuration, used only to shape the
   // time steps so that windows and hold periods are actually reached.
   logic [31:0]               now_stamp = '0;
   int                        window_now = 20;
   int                        hold_now = 1000;
   int                        samples_sent = 0;

   // Set by the stimulus to ask the receiver for one long hold-off.
   logic                      hold_off_due = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   button_press_hold_debouncer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bphd_event_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Watchdog. A hung handshake anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response back-pressure. Most of the time the receiver alternates short
   // ready stretches with short stalls; sometimes it stays ready for a long
   // stretch, and sometimes it stalls for a longer stretch. When the stimulus
   // asks for it, the receiver holds off for a long counted stretch so the
   // block fills up and must stall its input while requests keep coming.
   initial begin
      int pick;
      wait (!reset);
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 9);
         if (hold_off_due) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_due = 1'b0;
         end else if (pick < 2) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else if (pick < 9) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // Offers one sample transaction at the current time plus the given step,
   // waits until it is accepted, then idles the request channel for a random
   // gap. A zero gap leaves valid high so the next transaction follows
   // back to back. The step may be negative in two's complement, which makes
   // time run backwards.
   task automatic send_sample(input logic level, input logic [31:0] step_ms);
      req_type item;
      int      gap_pick;
      int      gap;
      now_stamp = now_stamp + step_ms;
      item.raw_level = level;
      item.now_ms = now_stamp;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      gap_pick = $urandom_range(0, 99);
      if (gap_pick < 65) begin
         gap = 0;
      end else if (gap_pick < 93) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(10, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every predicted response has
   // been taken, plus DRAIN_CYCLES more so the block is truly idle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB-style write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'({reg_sel, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // APB-style read; the checker compares the returned data.
   task automatic csr_read(input logic reg_sel);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_WIDTH'({reg_sel, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reprograms both registers once the block has gone idle. The upper data
   // bits carry random junk, which the 16-bit registers must drop.
   task automatic configure(input int window_ms, input int hold_ms);
      settle();
      csr_write(REG_DEBOUNCE, {16'($urandom), 16'(window_ms)});
      csr_read(REG_DEBOUNCE);
      csr_write(REG_HOLD, {16'($urandom), 16'(hold_ms)});
      csr_read(REG_HOLD);
      window_now = window_ms;
      hold_now = hold_ms;
   endtask

   // One well-formed press: some contact bounce, a low stretch that usually
   // outlasts the debounce window, a held stretch that can reach one or more
   // hold periods, an optional bounce on release, and a high stretch.
   task automatic press_episode();
      repeat ($urandom_range(0, 3)) begin
         send_sample(1'($urandom), $urandom_range(0, window_now / 2 + 1));
      end
      repeat ($urandom_range(2, 5)) begin
         send_sample(PIN_LOW, $urandom_range(0, window_now / 2 + 2));
      end
      repeat ($urandom_range(1, 6)) begin
         send_sample(PIN_LOW, $urandom_range(0, hold_now + hold_now / 2 + 1));
      end
      if ($urandom_range(0, 2) == 0) begin
         send_sample(PIN_HIGH, $urandom_range(0, window_now / 2));
         send_sample(PIN_LOW, $urandom_range(0, window_now / 2));
      end
      repeat ($urandom_range(2, 5)) begin
         send_sample(PIN_HIGH, $urandom_range(0, window_now / 2 + 2));
      end
   endtask

   // A short burst of arbitrary samples: random levels with repeated
   // timestamps, ordinary steps, jumps anywhere in the 32-bit range, and
   // steps backwards in time.
   task automatic noise_burst();
      int pick;
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            send_sample(1'($urandom), 32'd0);
         end else if (pick < 6) begin
            send_sample(1'($urandom), $urandom_range(0, 3 * window_now + 3));
         end else if (pick < 8) begin
            send_sample(1'($urandom), $urandom);
         end else begin
            send_sample(1'($urandom), -32'($urandom_range(1, window_now + 2)));
         end
      end
   endtask

   // Mostly well-formed presses, with noise mixed in, until the requested
   // number of samples has been accepted.
   task automatic random_phase(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            press_episode();
         end else begin
            noise_burst();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers must come out of reset at 20 ms and 1000 ms.
      csr_read(REG_DEBOUNCE);
      csr_read(REG_HOLD);

      // Directed walk with the reset configuration, starting at time zero.
      send_sample(PIN_HIGH, 32'd0);     // released pin while idle does nothing
      send_sample(PIN_LOW, 32'd5);      // low edge opens a press window
      send_sample(PIN_HIGH, 32'd3);     // bounce during a pending press: back to idle
      send_sample(PIN_LOW, 32'd0);      // new press window at 8 ms
      send_sample(PIN_LOW, 32'd19);     // one millisecond short of the window
      send_sample(PIN_LOW, 32'd1);      // exactly the window: press confirmed
      send_sample(PIN_LOW, 32'd999);    // one short of the hold period
      send_sample(PIN_LOW, 32'd1);      // hold event
      send_sample(PIN_LOW, 32'd1000);   // the timer re-armed, so it repeats
      send_sample(PIN_HIGH, 32'd4);     // release edge opens a release window
      send_sample(PIN_LOW, 32'd2);      // bounce during a pending release: press pending
      send_sample(PIN_LOW, 32'd20);     // press confirmed again
      send_sample(PIN_HIGH, 32'd1);     // release pending
      send_sample(PIN_HIGH, 32'd20);    // release confirmed
      send_sample(PIN_LOW, 32'd100);    // press pending
      send_sample(PIN_LOW, -32'd1);     // time ran backwards: counts as expired
      send_sample(PIN_HIGH, 32'd0);     // release pending
      send_sample(PIN_HIGH, -32'd1);    // backwards again: release confirmed

      // Press window straddling the wrap of the millisecond counter, passing
      // through the all-ones timestamp.
      now_stamp = 32'hFFFF_FFF8;
      send_sample(PIN_LOW, 32'd0);
      send_sample(PIN_LOW, 32'd7);
      send_sample(PIN_LOW, 32'd13);

      // Zero window and zero hold period: everything fires on the first
      // qualifying sample, even with no time passing.
      configure(0, 0);
      send_sample(PIN_LOW, 32'd0);
      send_sample(PIN_LOW, 32'd0);
      send_sample(PIN_LOW, 32'd0);
      send_sample(PIN_HIGH, 32'd0);
      send_sample(PIN_HIGH, 32'd0);
      random_phase(280);

      // Largest settings, with one long receiver hold-off early on.
      configure(65535, 65535);
      hold_off_due = 1'b1;
      random_phase(300);

      configure(1, 1);
      random_phase(250);

      configure(5, 30);
      hold_off_due = 1'b1;
      random_phase(300);

      configure($urandom_range(0, 65535), $urandom_range(0, 65535));
      random_phase(250);

      configure($urandom_range(0, 200), $urandom_range(0, 2000));
      random_phase(300);

      configure(20, 1000);
      random_phase(300);

      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
